// ===== rtl/core/isu_pkg.sv =====
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and codes for the interval set union insert block.
// ----------------------------------------------------------------------------
package isu_pkg;

  // Endpoint width, which the fixed field widths set.
  localparam int EP_W = 32;
  localparam int MAX_INTERVALS_DEF = 64;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Action codes.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_COVERED  = 3'd1;
  localparam logic [2:0] ACT_REPLACED = 3'd2;
  localparam logic [2:0] ACT_UPPER    = 3'd3;
  localparam logic [2:0] ACT_LOWER    = 3'd4;
  localparam logic [2:0] ACT_APPENDED = 3'd5;
  localparam logic [2:0] ACT_DROPPED  = 3'd6;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [EP_W-1:0] new_lower;
    logic signed [EP_W-1:0] new_upper;
    logic [5:0]             read_index;
  } isu_in_t;

  typedef struct packed {
    logic [2:0]             action;
    logic [5:0]             entry_slot;
    logic signed [EP_W-1:0] entry_low;
    logic signed [EP_W-1:0] entry_high;
    logic [6:0]             set_count;
    logic                   read_ok;
  } isu_out_t;

endpackage

// ===== rtl/core/isu_ram.sv =====
// ----------------------------------------------------------------------------
// isu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module isu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/interval_set_union_insert_top.sv =====
// ----------------------------------------------------------------------------
// interval_set_union_insert_top
// Bounded set of closed intervals; insert scans newest to oldest entry.
// ----------------------------------------------------------------------------
// An insert into a non-empty set scans stored entries up to a hit or the oldest
// entry, a read in range passes through the RAM read state, and an insert into an empty
// set, a clear, an unused command or a read out of range goes straight to the emit state.
// One item is in work at a time; the next is taken in the cycle after its result is
// loaded, later while an untaken result stalls it. Reset empties the set.
// ----------------------------------------------------------------------------
module interval_set_union_insert_top
  import isu_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  isu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output isu_out_t out_data
);

  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int DW = 2 * EP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state;
  logic [CW-1:0]          count;
  logic [IW-1:0]          ptr;
  logic [IW-1:0]          cur;
  logic                   dvalid;
  logic                   last_iss;
  logic signed [EP_W-1:0] nlo;
  logic signed [EP_W-1:0] nhi;
  logic [5:0]             ridx;
  isu_out_t               res;
  isu_out_t               res_next;

  logic                   we;
  logic [IW-1:0]          waddr;
  logic [DW-1:0]          wdata;
  logic [IW-1:0]          raddr;
  logic [DW-1:0]          rdata;
  logic signed [EP_W-1:0] e_lo;
  logic signed [EP_W-1:0] e_hi;
  logic                   hit_cov;
  logic                   hit_rep;
  logic                   hit_up;
  logic                   hit_low;
  logic                   in_xfer;
  logic                   out_free;
  logic                   rd_ok;
  logic                   scan_eval;
  logic                   no_hit_end;
  logic                   not_full;

  isu_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_INTERVALS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rd_ok    = (32'(in_data.read_index) < 32'(count))
                 && (32'(in_data.read_index) < 32'(MAX_INTERVALS));
  assign not_full = (32'(count) < 32'(MAX_INTERVALS));

  // Entry compare against the held interval.
  assign e_lo    = rdata[EP_W-1:0];
  assign e_hi    = rdata[DW-1:EP_W];
  assign hit_cov = (e_lo <= nlo) && (e_hi >= nhi);
  assign hit_rep = (e_lo >= nlo) && (e_hi <= nhi);
  assign hit_up  = (e_lo <= nlo) && (e_hi >= nlo);
  assign hit_low = (e_lo > nlo) && (e_lo <= nhi);

  assign scan_eval  = (state == ST_SCAN) && dvalid;
  assign no_hit_end = scan_eval && !(hit_cov || hit_rep || hit_up || hit_low)
                   && (cur == '0);

  // RAM port control: read address, write back on a non-covering hit or an append.
  always_comb begin
    raddr = (state == ST_IDLE) ? IW'(in_data.read_index) : ptr;
    we    = 1'b0;
    waddr = cur;
    wdata = {nhi, nlo};
    if (scan_eval && !hit_cov) begin
      if (hit_rep) begin
        we = 1'b1;
      end else if (hit_up) begin
        we    = 1'b1;
        wdata = {nhi, e_lo};
      end else if (hit_low) begin
        we    = 1'b1;
        wdata = {e_hi, nlo};
      end
    end
    if (no_hit_end && not_full) begin
      we    = 1'b1;
      waddr = IW'(count);
      wdata = {nhi, nlo};
    end
    // An insert into an empty set goes straight to the first slot.
    if (in_xfer && (in_data.cmd == CMD_INSERT) && (count == '0)) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {in_data.new_upper, in_data.new_lower};
    end
  end

  // Result fields, built up as the item moves through the sequencer.
  always_comb begin
    res_next = res;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          res_next = '0;
          case (in_data.cmd)
            CMD_INSERT: begin
              if (count == '0) begin
                res_next.entry_low  = in_data.new_lower;
                res_next.entry_high = in_data.new_upper;
                res_next.action     = not_full ? ACT_APPENDED : ACT_DROPPED;
              end
            end
            CMD_READ: begin
              res_next.entry_slot = in_data.read_index;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_eval) begin
          res_next.entry_slot = 6'(cur);
          if (hit_cov) begin
            res_next.action     = ACT_COVERED;
            res_next.entry_low  = e_lo;
            res_next.entry_high = e_hi;
          end else if (hit_rep) begin
            res_next.action     = ACT_REPLACED;
            res_next.entry_low  = nlo;
            res_next.entry_high = nhi;
          end else if (hit_up) begin
            res_next.action     = ACT_UPPER;
            res_next.entry_low  = e_lo;
            res_next.entry_high = nhi;
          end else if (hit_low) begin
            res_next.action     = ACT_LOWER;
            res_next.entry_low  = nlo;
            res_next.entry_high = e_hi;
          end else if (no_hit_end) begin
            res_next.entry_low  = nlo;
            res_next.entry_high = nhi;
            if (not_full) begin
              res_next.action     = ACT_APPENDED;
              res_next.entry_slot = 6'(count);
            end else begin
              res_next.action     = ACT_DROPPED;
              res_next.entry_slot = '0;
            end
          end
        end
      end
      ST_READ: begin
        res_next.entry_slot = ridx;
        res_next.entry_low  = e_lo;
        res_next.entry_high = e_hi;
        res_next.read_ok    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, scan pointers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dvalid    <= 1'b0;
      last_iss  <= 1'b0;
    end else begin
      res <= res_next;
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            nlo  <= in_data.new_lower;
            nhi  <= in_data.new_upper;
            ridx <= in_data.read_index;
            case (in_data.cmd)
              CMD_INSERT: begin
                if (count == '0) begin
                  if (not_full) begin
                    count <= count + CW'(1);
                  end
                  state <= ST_EMIT;
                end else begin
                  ptr      <= IW'(count - CW'(1));
                  dvalid   <= 1'b0;
                  last_iss <= 1'b0;
                  state    <= ST_SCAN;
                end
              end
              CMD_READ: begin
                state <= rd_ok ? ST_READ : ST_EMIT;
              end
              CMD_CLEAR: begin
                count <= '0;
                state <= ST_EMIT;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue the next read while the previous entry is checked.
          dvalid <= !last_iss;
          if (!last_iss) begin
            cur <= ptr;
            if (ptr == '0) begin
              last_iss <= 1'b1;
            end else begin
              ptr <= ptr - IW'(1);
            end
          end
          if (scan_eval) begin
            if (hit_cov || hit_rep || hit_up || hit_low) begin
              state <= ST_EMIT;
            end else if (no_hit_end) begin
              if (not_full) begin
                count <= count + CW'(1);
              end
              state <= ST_EMIT;
            end
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Move the result into the output register once it is free.
          if (out_free) begin
            out_data <= {res.action, res.entry_slot, res.entry_low, res.entry_high,
                         7'(count), res.read_ok};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
